// File: rtl/iie_pkg.sv
// Shared types, opcode masks and flag constants for the immediate execute block.
`timescale 1ns / 1ps

package iie_pkg;

  // Opcode pattern matching
  localparam logic [7:0] LXI_MASK = 8'hCF;
  localparam logic [7:0] LXI_CODE = 8'h01;
  localparam logic [7:0] MVI_MASK = 8'hC7;
  localparam logic [7:0] MVI_CODE = 8'h06;
  localparam logic [7:0] ALU_MASK = 8'hC7;
  localparam logic [7:0] ALU_CODE = 8'hC6;

  // Register file layout: B,C,D,E,H,L,A
  localparam int unsigned REG_COUNT = 7;
  localparam logic [2:0] IDX_H = 3'd4;
  localparam logic [2:0] IDX_L = 3'd5;
  localparam logic [2:0] IDX_A = 3'd6;

  // Operand codes in opcode bits 5:3
  localparam logic [2:0] DST_M = 3'd6;
  localparam logic [2:0] DST_A = 3'd7;
  localparam logic [1:0] PAIR_SP = 2'd3;

  localparam logic [7:0] FLAG_RESET = 8'h02;

  localparam logic [1:0] PC_STEP_LXI = 2'd3;
  localparam logic [1:0] PC_STEP_IMM = 2'd2;
  localparam logic [3:0] CYC_LONG = 4'd10;
  localparam logic [3:0] CYC_SHORT = 4'd7;

  typedef enum logic [2:0] {
    ALU_ADI = 3'd0,
    ALU_ACI = 3'd1,
    ALU_SUI = 3'd2,
    ALU_SBI = 3'd3,
    ALU_ANI = 3'd4,
    ALU_XRI = 3'd5,
    ALU_ORI = 3'd6,
    ALU_CPI = 3'd7
  } alu_kind_t;

  typedef struct packed {
    logic [REG_COUNT-1:0][7:0] regs;
    logic [7:0]                flags;
    logic [15:0]               sp;
  } arch_state_t;

  typedef struct packed {
    logic [7:0]  acc_value;
    logic [7:0]  flag_byte;
    logic        mem_write;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
    logic [1:0]  pc_step;
    logic [3:0]  cycle_cost;
    logic        unsupported;
  } exec_result_t;

endpackage

// File: rtl/iie_exec.sv
// Combinational execute logic: decode, ALU, flags and next architectural state.
`timescale 1ns / 1ps

module iie_exec (
  input  logic [7:0]           op,
  input  logic [7:0]           imm_lo,
  input  logic [7:0]           imm_hi,
  input  iie_pkg::arch_state_t cur,
  output iie_pkg::arch_state_t nxt,
  output iie_pkg::exec_result_t res
);

  logic                is_lxi, is_mvi, is_alu;
  logic [1:0]          pair;
  logic [2:0]          dst;
  iie_pkg::alu_kind_t  kind;
  logic [7:0]          acc, opnd, alu_out, new_flags;
  logic                cy_in, cin, is_sub, c7, c3, logical;
  logic [8:0]          sum9;
  logic [4:0]          sum5;

  assign is_lxi = (op & iie_pkg::LXI_MASK) == iie_pkg::LXI_CODE;
  assign is_mvi = (op & iie_pkg::MVI_MASK) == iie_pkg::MVI_CODE;
  assign is_alu = (op & iie_pkg::ALU_MASK) == iie_pkg::ALU_CODE;
  assign pair   = op[5:4];
  assign dst    = op[5:3];
  assign kind   = iie_pkg::alu_kind_t'(op[5:3]);
  assign acc    = cur.regs[iie_pkg::IDX_A];
  assign cy_in  = cur.flags[0];

  always_comb begin
    is_sub  = 1'b0;
    cin     = 1'b0;
    logical = 1'b0;
    case (kind) inside
      iie_pkg::ALU_ADI:                  cin = 1'b0;
      iie_pkg::ALU_ACI:                  cin = cy_in;
      iie_pkg::ALU_SUI, iie_pkg::ALU_CPI: begin
        is_sub = 1'b1;
        cin    = 1'b1;
      end
      iie_pkg::ALU_SBI: begin
        is_sub = 1'b1;
        cin    = ~cy_in;
      end
      default:                           logical = 1'b1;
    endcase
  end

  assign opnd = is_sub ? ~imm_lo : imm_lo;
  assign sum9 = {1'b0, acc} + {1'b0, opnd} + {8'd0, cin};
  assign sum5 = {1'b0, acc[3:0]} + {1'b0, opnd[3:0]} + {4'd0, cin};

  always_comb begin
    case (kind)
      iie_pkg::ALU_ANI: alu_out = acc & imm_lo;
      iie_pkg::ALU_XRI: alu_out = acc ^ imm_lo;
      iie_pkg::ALU_ORI: alu_out = acc | imm_lo;
      default:          alu_out = sum9[7:0];
    endcase
  end

  // Logical ops clear carry and aux carry; subtracts invert the carry out
  assign c7 = logical ? 1'b0 : (sum9[8] ^ is_sub);
  assign c3 = logical ? 1'b0 : sum5[4];

  assign new_flags = {alu_out[7], (alu_out == 8'd0), 1'b0, c3, 1'b0, ~^alu_out, 1'b1, c7};

  always_comb begin
    nxt             = cur;
    res.mem_write   = 1'b0;
    res.mem_addr    = 16'd0;
    res.mem_data    = 8'd0;
    res.pc_step     = 2'd0;
    res.cycle_cost  = 4'd0;
    res.unsupported = 1'b0;
    if (is_lxi) begin
      if (pair == iie_pkg::PAIR_SP) begin
        nxt.sp = {imm_hi, imm_lo};
      end else begin
        nxt.regs[{pair, 1'b0}] = imm_hi;
        nxt.regs[{pair, 1'b1}] = imm_lo;
      end
      res.pc_step    = iie_pkg::PC_STEP_LXI;
      res.cycle_cost = iie_pkg::CYC_LONG;
    end else if (is_mvi) begin
      if (dst == iie_pkg::DST_M) begin
        res.mem_write  = 1'b1;
        res.mem_addr   = {cur.regs[iie_pkg::IDX_H], cur.regs[iie_pkg::IDX_L]};
        res.mem_data   = imm_lo;
        res.cycle_cost = iie_pkg::CYC_LONG;
      end else begin
        nxt.regs[(dst == iie_pkg::DST_A) ? iie_pkg::IDX_A : dst] = imm_lo;
        res.cycle_cost = iie_pkg::CYC_SHORT;
      end
      res.pc_step = iie_pkg::PC_STEP_IMM;
    end else if (is_alu) begin
      nxt.flags = new_flags;
      if (kind != iie_pkg::ALU_CPI) begin
        nxt.regs[iie_pkg::IDX_A] = alu_out;
      end
      res.pc_step    = iie_pkg::PC_STEP_IMM;
      res.cycle_cost = iie_pkg::CYC_SHORT;
    end else begin
      res.unsupported = 1'b1;
    end
    res.acc_value = nxt.regs[iie_pkg::IDX_A];
    res.flag_byte = nxt.flags;
  end

endmodule

// File: rtl/immediate_instruction_execute.sv
// Top level of the 8080 immediate-instruction execute block.
`timescale 1ns / 1ps

// Executes one 8080 immediate instruction (LXI, MVI, ADI/ACI/SUI/SBI/ANI/XRI/ORI/CPI)
// per input transaction and returns exactly one result transaction for it. The block
// holds B,C,D,E,H,L,A, the flag byte and SP; reset clears the registers and SP and
// sets the flags to 0x02. An input transaction is captured in an input register and
// executed against the register state once the result register can take it; the state
// updates as the result register loads. One instruction completes per cycle while the
// output is not stalled, so transactions may arrive back to back. A transaction passes
// through the input register and then the result register; the 8-bit add with flag
// generation is the longest path between them. Opcodes that are not immediate
// instructions return with unsupported set and change nothing.

module immediate_instruction_execute (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_op,
  input  logic [7:0]  in_imm_lo,
  input  logic [7:0]  in_imm_hi,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_acc_value,
  output logic [7:0]  out_flag_byte,
  output logic        out_mem_write,
  output logic [15:0] out_mem_addr,
  output logic [7:0]  out_mem_data,
  output logic [1:0]  out_pc_step,
  output logic [3:0]  out_cycle_cost,
  output logic        out_unsupported
);

  // Input register
  logic       in_v_r, in_v_nxt;
  logic [7:0] op_r, lo_r, hi_r;

  // Architectural state and result register
  iie_pkg::arch_state_t  st_r, st_nxt;
  iie_pkg::exec_result_t res_r, res_nxt;
  logic                  out_v_r, out_v_nxt;

  logic in_take;
  logic exec_fire;

  // Execute when the result register is empty or draining this cycle
  assign exec_fire = in_v_r && (!out_v_r || !out_stall);
  // Hold the input side only while a captured transaction cannot advance
  assign in_stall  = in_v_r && !exec_fire;
  assign in_take   = in_valid && !in_stall;

  iie_exec u_exec (
    .op     (op_r),
    .imm_lo (lo_r),
    .imm_hi (hi_r),
    .cur    (st_r),
    .nxt    (st_nxt),
    .res    (res_nxt)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (exec_fire) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (exec_fire) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      st_r.regs  <= '0;
      st_r.flags <= iie_pkg::FLAG_RESET;
      st_r.sp    <= 16'd0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      // Advance architectural state only as the transaction retires
      if (exec_fire) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r <= in_op;
      lo_r <= in_imm_lo;
      hi_r <= in_imm_hi;
    end
    if (exec_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_acc_value   = res_r.acc_value;
  assign out_flag_byte   = res_r.flag_byte;
  assign out_mem_write   = res_r.mem_write;
  assign out_mem_addr    = res_r.mem_addr;
  assign out_mem_data    = res_r.mem_data;
  assign out_pc_step     = res_r.pc_step;
  assign out_cycle_cost  = res_r.cycle_cost;
  assign out_unsupported = res_r.unsupported;

  // An unsupported opcode reports no step, no cycles and no memory write
  a_unsup_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unsupported) |->
      (out_pc_step == 2'd0 && out_cycle_cost == 4'd0 && !out_mem_write))
    else $error("unsupported result carries activity");

  // A memory write comes only from MVI M
  a_memwr_cost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mem_write) |->
      (out_cycle_cost == iie_pkg::CYC_LONG && out_pc_step == iie_pkg::PC_STEP_IMM))
    else $error("memory write with wrong step or cost");

  // Fixed flag bits: bit1 set, bits 5 and 3 clear
  a_flag_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_flag_byte[1] && !out_flag_byte[5] && !out_flag_byte[3]))
    else $error("fixed flag bits wrong");

  // A captured transaction with room downstream yields a result next cycle
  a_exec_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !out_stall) |=> out_valid)
    else $error("captured transaction did not advance");

  // No step without a captured transaction
  a_exec_src: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |-> in_v_r && !in_stall)
    else $error("execute without pending transaction");

endmodule
